@@ sv/line_span_rasterizer_assert.svh @@
// Assertion macros for the line span rasterizer checker.
// Needs a clk_i and rst_ni in the scope of each use.
`ifndef LINE_SPAN_RASTERIZER_ASSERT_SVH
`define LINE_SPAN_RASTERIZER_ASSERT_SVH

// Same-cycle implication.
`define LSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsr assertion failed");

// Next-cycle implication.
`define LSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsr assertion failed");

`endif

@@ sv/lsr_pkg.sv @@
// Shared types and constants of the line span rasterizer.
// Used by lsr_div, line_span_rasterizer and lsr_checker.
package lsr_pkg;

  localparam int unsigned COLOR_BITS = 16;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } lsr_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } lsr_div_stat_t;

endpackage

@@ sv/lsr_div.sv @@
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on lsr_pkg for the status struct.
module lsr_div import lsr_pkg::*; #(
  parameter int W = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [W-1:0]  divisor_i,
  output logic [W-1:0]  quotient_o,
  output lsr_div_stat_t stat_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [W:0]    rem_shift;
  logic [W:0]    diff;
  logic          take;

  assign rem_shift = {rem_q, quo_q[W-1]};
  assign diff      = rem_shift - {1'b0, dvs_q};
  assign take      = rem_shift >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? diff[W-1:0] : rem_shift[W-1:0];
      quo_d = {quo_q[W-2:0], take};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ sv/line_span_rasterizer.sv @@
// Line span rasterizer: cuts a line into filled rectangles, one per request.
// A request channel (in_valid_i/in_ready_o) takes a start item (req_type 0, two
// endpoints) or a next item (req_type 1). Each transfer yields exactly one
// result on the span channel (out_valid_o/out_ready_i): a span, or no_span_o
// high with all other fields zero when next is asked with no line active.
// The config channel (cfg_valid_i/cfg_ready_o) writes draw_color; it is always
// ready and should only be written while the block is idle.
// A span passes through the prep and load setup states, the serial divider and
// the finish state on its way to out_valid_o. The block is ready again in the
// cycle the result shows. An empty result skips setup and the divider and goes
// straight to the finish state. One request is in flight.
// The result sits in an output register; a new request is taken while it
// waits, and the finish step holds until that register is free.
// Reset clears the color, the cursor and the active-line flag.
// Depends on lsr_pkg and lsr_div.
module line_span_rasterizer import lsr_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [COLOR_BITS-1:0]        cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] span_x_o,
  output logic signed [COORD_BITS:0]   span_y_o,
  output logic [COORD_BITS:0]          span_w_o,
  output logic [COORD_BITS:0]          span_h_o,
  output logic [COLOR_BITS-1:0]        span_color_o,
  output logic                         span_last_o,
  output logic                         no_span_o
);

  localparam int CB = COORD_BITS;
  localparam int MW = COORD_BITS + 1;   // span sizes and divider width
  localparam int XW = COORD_BITS + 2;   // headroom for differences

  lsr_state_e state_q, state_d;

  logic [COLOR_BITS-1:0] color_q;
  logic signed [MW-1:0]  cur_x_q, cur_x_d;
  logic signed [MW-1:0]  cur_y_q, cur_y_d;
  logic signed [CB-1:0]  tgt_x_q, tgt_x_d;
  logic signed [CB-1:0]  tgt_y_q, tgt_y_d;
  logic                  active_q, active_d;
  logic                  empty_q, empty_d;

  logic [MW-1:0]         dx_q, my_q;
  logic                  neg_q, ymaj_q;

  logic                  out_valid_q;
  logic signed [CB-1:0]  out_x_q;
  logic signed [MW-1:0]  out_y_q;
  logic [MW-1:0]         out_w_q, out_h_q;
  logic [COLOR_BITS-1:0] out_color_q;
  logic                  out_last_q, out_empty_q;

  logic                  in_fire;
  logic                  do_prep, do_load, fin_fire;
  logic                  div_start;
  logic [MW-1:0]         div_a, div_b, quotient;
  lsr_div_stat_t         div_stat;

  logic signed [XW-1:0]  dx_full, dy_full, my_full;
  logic [MW-1:0]         w_span, h_span;
  logic signed [MW-1:0]  y_top, x_next, y_next;
  logic                  last_span;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_START || active_q) state_d = ST_PREP;
          else state_d = ST_FINISH;
        end
      end
      ST_PREP:   state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_stat.done) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    do_prep    = 1'b0;
    do_load    = 1'b0;
    fin_fire   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_PREP:   do_prep = 1'b1;
      ST_LOAD:   do_load = 1'b1;
      ST_DIVIDE: ;
      ST_FINISH: fin_fire = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // ---------------- setup arithmetic ----------------
  assign dx_full = XW'(tgt_x_q) - XW'(cur_x_q) + XW'(1);
  assign dy_full = XW'(tgt_y_q) - XW'(cur_y_q);
  // grow dy by one away from zero, keep its magnitude
  assign my_full = dy_full[XW-1] ? (XW'(1) - dy_full) : (dy_full + XW'(1));

  assign div_start = do_load;
  assign div_a     = ymaj_q ? my_q : dx_q;
  assign div_b     = ymaj_q ? dx_q : my_q;

  lsr_div #(.W(MW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // ---------------- finish arithmetic ----------------
  assign w_span    = ymaj_q ? MW'(1) : quotient;
  assign h_span    = ymaj_q ? quotient : MW'(1);
  assign y_top     = cur_y_q - $signed(h_span);
  assign x_next    = cur_x_q + $signed(w_span);
  assign y_next    = neg_q ? y_top : (cur_y_q + $signed(h_span));
  assign last_span = x_next > MW'(tgt_x_q);

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    active_d = active_q;
    empty_d  = empty_q;
    if (in_fire) begin
      empty_d = (req_type_i == REQ_NEXT) && !active_q;
      if (req_type_i == REQ_START) begin
        active_d = 1'b1;
        // order the endpoints by rising x
        if (start_x_i > end_x_i) begin
          cur_x_d = MW'(end_x_i);
          cur_y_d = MW'(end_y_i);
          tgt_x_d = start_x_i;
          tgt_y_d = start_y_i;
        end else begin
          cur_x_d = MW'(start_x_i);
          cur_y_d = MW'(start_y_i);
          tgt_x_d = end_x_i;
          tgt_y_d = end_y_i;
        end
      end
    end else if (fin_fire && !empty_q) begin
      cur_x_d = x_next;
      cur_y_d = y_next;
      if (last_span) active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      color_q     <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      active_q    <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      active_q <= active_d;
      empty_q  <= empty_d;
      if (cfg_valid_i && cfg_ready_o) color_q <= cfg_wdata_i;
      if (fin_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // setup and result payload
  always_ff @(posedge clk_i) begin
    if (do_prep) begin
      dx_q   <= dx_full[MW-1:0];
      my_q   <= my_full[MW-1:0];
      neg_q  <= dy_full[XW-1];
      // pick the major axis now so the divider operands are ready at load
      ymaj_q <= my_full[MW-1:0] > dx_full[MW-1:0];
    end
    if (fin_fire) begin
      if (empty_q) begin
        out_x_q     <= '0;
        out_y_q     <= '0;
        out_w_q     <= '0;
        out_h_q     <= '0;
        out_color_q <= '0;
        out_last_q  <= 1'b0;
        out_empty_q <= 1'b1;
      end else begin
        out_x_q     <= cur_x_q[CB-1:0];
        out_y_q     <= neg_q ? y_top : cur_y_q;
        out_w_q     <= w_span;
        out_h_q     <= h_span;
        out_color_q <= color_q;
        out_last_q  <= last_span;
        out_empty_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign span_x_o     = out_x_q;
  assign span_y_o     = out_y_q;
  assign span_w_o     = out_w_q;
  assign span_h_o     = out_h_q;
  assign span_color_o = out_color_q;
  assign span_last_o  = out_last_q;
  assign no_span_o    = out_empty_q;

endmodule

@@ sv/lsr_checker.sv @@
// Port-level checks for line_span_rasterizer, attached by bind.
// Depends on lsr_pkg and line_span_rasterizer_assert.svh.
`include "line_span_rasterizer_assert.svh"

module lsr_checker import lsr_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [COORD_BITS:0]   span_w_o,
  input logic [COORD_BITS:0]   span_h_o,
  input logic [COLOR_BITS-1:0] span_color_o,
  input logic                  span_last_o,
  input logic                  no_span_o
);

  // a stalled result stays valid
  `LSR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // one request in flight: ready drops after every transfer
  `LSR_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && in_ready_o, !in_ready_o)

  // an empty result carries nothing else
  `LSR_ASSERT_NOW(a_empty_clean, out_valid_o && no_span_o,
    span_w_o == '0 && span_h_o == '0 && span_color_o == '0 && !span_last_o)

  // every span is non-empty and thin along its minor axis
  `LSR_ASSERT_NOW(a_span_shape, out_valid_o && !no_span_o,
    span_w_o != '0 && span_h_o != '0 && (span_w_o == 1 || span_h_o == 1))

endmodule

bind line_span_rasterizer lsr_checker #(.COORD_BITS(COORD_BITS)) u_lsr_checker (.*);

@@ test/line_span_rasterizer_test.sv @@
// Self-checking testbench for line_span_rasterizer: directed lines, then random line sequences,
// with random idling on both channels and a span predictor that checks every result.
// Depends on lsr_pkg and the line_span_rasterizer RTL.
module line_span_rasterizer_test import lsr_pkg::*; ();

  localparam int COORD_BITS = 11;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic kind;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
  } line_req_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS:0] y;
    logic [COORD_BITS:0] w;
    logic [COORD_BITS:0] h;
    logic [COLOR_BITS-1:0] color;
    logic last;
    logic none;
  } span_t;

  typedef struct {
    logic signed [COORD_BITS:0] cur_x;
    logic signed [COORD_BITS:0] cur_y;
    logic signed [COORD_BITS-1:0] tgt_x;
    logic signed [COORD_BITS-1:0] tgt_y;
    logic active;
  } line_state_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [COLOR_BITS-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic req_type_i;
  logic signed [COORD_BITS-1:0] start_x_i;
  logic signed [COORD_BITS-1:0] start_y_i;
  logic signed [COORD_BITS-1:0] end_x_i;
  logic signed [COORD_BITS-1:0] end_y_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [COORD_BITS-1:0] span_x_o;
  logic signed [COORD_BITS:0] span_y_o;
  logic [COORD_BITS:0] span_w_o;
  logic [COORD_BITS:0] span_h_o;
  logic [COLOR_BITS-1:0] span_color_o;
  logic span_last_o;
  logic no_span_o;

  line_req_t request_q[$];
  span_t pending_spans[$];
  line_state_t plan_line;
  line_state_t track_line;
  logic [COLOR_BITS-1:0] color_now;
  line_req_t drive_req;
  span_t want_span;
  span_t dummy_span;
  bit in_taken;
  int send_idle_pct;
  int recv_idle_pct;
  int item_count;
  int error_count;
  int quiet_cycles;

  line_span_rasterizer #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .req_type_i(req_type_i),
    .start_x_i(start_x_i),
    .start_y_i(start_y_i),
    .end_x_i(end_x_i),
    .end_y_i(end_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .span_x_o(span_x_o),
    .span_y_o(span_y_o),
    .span_w_o(span_w_o),
    .span_h_o(span_h_o),
    .span_color_o(span_color_o),
    .span_last_o(span_last_o),
    .no_span_o(no_span_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advance the line cursor by one request and return the span it produces.
  function automatic span_t next_span(inout line_state_t st, input line_req_t req,
                                      input logic [COLOR_BITS-1:0] color);
    span_t s;
    int dx;
    int dy;
    int mag;
    s.x = '0;
    s.y = '0;
    s.w = '0;
    s.h = '0;
    s.color = '0;
    s.last = 1'b0;
    s.none = 1'b0;
    if (req.kind == REQ_START) begin
      if (req.ax > req.bx) begin
        st.cur_x = (COORD_BITS+1)'(req.bx);
        st.cur_y = (COORD_BITS+1)'(req.by);
        st.tgt_x = req.ax;
        st.tgt_y = req.ay;
      end else begin
        st.cur_x = (COORD_BITS+1)'(req.ax);
        st.cur_y = (COORD_BITS+1)'(req.ay);
        st.tgt_x = req.bx;
        st.tgt_y = req.by;
      end
      st.active = 1'b1;
    end
    if (!st.active) begin
      s.none = 1'b1;
      return s;
    end
    dx = int'(st.tgt_x) - int'(st.cur_x) + 1;
    dy = int'(st.tgt_y) - int'(st.cur_y);
    if (dy >= 0) dy++;
    else dy--;
    mag = (dy < 0) ? -dy : dy;
    // Divide the longer leg by the shorter one; the shorter becomes a unit step.
    if (mag > dx) begin
      dy = dy / dx;
      dx = 1;
    end else begin
      dx = dx / mag;
      dy = (dy < 0) ? -1 : 1;
    end
    s.x = st.cur_x[COORD_BITS-1:0];
    s.w = (COORD_BITS+1)'(dx);
    if (dy > 0) begin
      s.y = st.cur_y;
      s.h = (COORD_BITS+1)'(dy);
    end else begin
      s.y = (COORD_BITS+1)'(int'(st.cur_y) + dy);
      s.h = (COORD_BITS+1)'(-dy);
    end
    s.color = color;
    st.cur_x = (COORD_BITS+1)'(int'(st.cur_x) + dx);
    st.cur_y = (COORD_BITS+1)'(int'(st.cur_y) + dy);
    s.last = int'(st.cur_x) > int'(st.tgt_x);
    if (s.last) st.active = 1'b0;
    return s;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 1023 : -1024;
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v > 1023) return 1023;
    if (v < -1024) return -1024;
    return v;
  endfunction

  function automatic int near_coord(input int base, input int reach);
    return clamp_coord(base + int'($urandom_range(0, 2 * reach)) - reach);
  endfunction

  task automatic report_error(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%h want 0x%h", name, got, want));
  endtask

  // Queue one request and follow it in the planning copy of the line state.
  task automatic add_item(input logic kind, input int ax, input int ay, input int bx,
                          input int by);
    line_req_t req;
    req.kind = kind;
    req.ax = COORD_BITS'(ax);
    req.ay = COORD_BITS'(ay);
    req.bx = COORD_BITS'(bx);
    req.by = COORD_BITS'(by);
    request_q.push_back(req);
    dummy_span = next_span(plan_line, req, '0);
    item_count++;
  endtask

  task automatic add_next();
    add_item(REQ_NEXT, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Start a line, then ask for spans until it ends or the cap is hit.
  task automatic add_line(input int ax, input int ay, input int bx, input int by,
                          input int max_next);
    int n;
    n = 0;
    add_item(REQ_START, ax, ay, bx, by);
    while (plan_line.active && n < max_next) begin
      add_next();
      n++;
    end
  endtask

  task automatic add_sequence();
    int sel;
    int ax;
    int ay;
    int reach;
    sel = $urandom_range(0, 99);
    ax = rand_coord();
    ay = rand_coord();
    reach = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 40);
    if (sel < 65) begin
      add_line(ax, ay, near_coord(ax, reach), near_coord(ay, reach), 1000);
    end else if (sel < 75) begin
      if ($urandom_range(0, 1))
        add_line(ax, ay, rand_coord(), near_coord(ay, 3), 1000);
      else
        add_line(ax, ay, near_coord(ax, 2), rand_coord(), 1000);
    end else if (sel < 85) begin
      // Drop the line early; the next start replaces it.
      add_line(ax, ay, near_coord(ax, reach), near_coord(ay, reach), $urandom_range(0, 2));
    end else if (sel < 93) begin
      repeat ($urandom_range(1, 3)) add_next();
    end else begin
      add_line(ax, ay, rand_coord(), rand_coord(), $urandom_range(0, 30));
    end
  endtask

  task automatic run_phase(input int count);
    int stop;
    stop = item_count + count;
    while (item_count < stop) add_sequence();
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || pending_spans.size() != 0);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic write_color(input logic [COLOR_BITS-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Request driver: present the next queued request once the current one transfers.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drive_req = request_q.pop_front();
          req_type_i <= drive_req.kind;
          start_x_i <= drive_req.ax;
          start_y_i <= drive_req.ay;
          end_x_i <= drive_req.bx;
          end_y_i <= drive_req.by;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      in_taken = 1'b0;
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each request transfer, check each span transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) color_now = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        drive_req.kind = req_type_i;
        drive_req.ax = start_x_i;
        drive_req.ay = start_y_i;
        drive_req.bx = end_x_i;
        drive_req.by = end_y_i;
        pending_spans.push_back(next_span(track_line, drive_req, color_now));
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_spans.size() == 0) begin
          report_error("span transfer with no request outstanding");
        end else begin
          want_span = pending_spans.pop_front();
          check_field("span_x", 16'(span_x_o), 16'(want_span.x));
          check_field("span_y", 16'(span_y_o), 16'(want_span.y));
          check_field("span_w", 16'(span_w_o), 16'(want_span.w));
          check_field("span_h", 16'(span_h_o), 16'(want_span.h));
          check_field("span_color", span_color_o, want_span.color);
          check_field("span_last", 16'(span_last_o), 16'(want_span.last));
          check_field("no_span", 16'(no_span_o), 16'(want_span.none));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    req_type_i = REQ_START;
    start_x_i = '0;
    start_y_i = '0;
    end_x_i = '0;
    end_y_i = '0;
    out_ready_i = 1'b0;
    in_taken = 1'b0;
    color_now = '0;
    plan_line = '{cur_x: '0, cur_y: '0, tgt_x: '0, tgt_y: '0, active: 1'b0};
    track_line = plan_line;
    item_count = 0;
    error_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 16;
    recv_idle_pct = 50;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines under the reset color.
    add_next();                              // next with no line
    add_line(0, 0, 0, 0, 1000);              // single pixel
    add_line(-1024, 0, 1023, 0, 1000);       // full width
    add_line(7, -1024, 7, 1023, 1000);       // full height, downward
    add_line(-3, 1023, -3, -1024, 1000);     // full height, upward
    add_line(-1024, -1024, -1024, -1024, 1000);
    add_line(1023, 1023, 1023, 1023, 1000);
    add_line(10, 2, 0, -3, 1000);            // endpoints swapped
    add_line(0, 0, 4, 1, 1000);              // truncating divide
    add_line(0, 0, 2, -7, 1000);             // steep upward
    add_line(-20, -20, 20, 10, 1);           // dropped by the next start
    add_line(100, 100, 90, 120, 1000);
    add_next();                              // next after the line ended
    wait_idle();

    write_color(16'hFFFF);
    run_phase(630);
    wait_idle();

    send_idle_pct = 50;
    recv_idle_pct = 16;
    write_color(16'h0000);
    run_phase(630);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_color(COLOR_BITS'($urandom_range(1, 16'hFFFE)));
    run_phase(630);
    wait_idle();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
